// File: hdl/nsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsw_pkg
// Shared types and codes for the nonce-checked stop-and-wait link.
// ----------------------------------------------------------------------------
package nsw_pkg;

	localparam int unsigned NONCE_W    = 32;
	localparam int unsigned NODE_W     = 8;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned TICK_W     = 16;
	localparam int unsigned RETRY_W    = 8;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned ACT_W      = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W  = 128;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 72;
	localparam int unsigned OUT_USER_W = 4;

	localparam logic [KIND_W-1:0] KIND_PKT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

	localparam logic [BYTE_W-1:0] MSG_DATA    = 8'h01;
	localparam logic [BYTE_W-1:0] MSG_ACK     = 8'h02;
	localparam logic [BYTE_W-1:0] MSG_NACK    = 8'h03;
	localparam logic [BYTE_W-1:0] RESP_LENGTH = 8'd10;

	localparam logic [ACT_W-1:0] ACT_ACK   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_NACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FRAME = 3'd2;
	localparam logic [ACT_W-1:0] ACT_OK    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FAIL  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

	localparam logic [NODE_W-1:0]  GATEWAY_ID_RST  = 8'd1;
	localparam logic [TICK_W-1:0]  RETRY_WAIT_RST  = 16'd200;
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd5;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [NODE_W-1:0]  from_node;
		logic [BYTE_W-1:0]  msg_type;
		logic [BYTE_W-1:0]  packet_length;
		logic [NONCE_W-1:0] nonce_in_first;
		logic [NONCE_W-1:0] nonce_in_second;
		logic [BYTE_W-1:0]  signal_strength;
		logic [NONCE_W-1:0] fresh_nonce;
	} item_t;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [NONCE_W-1:0] nonce_out_first;
		logic [NONCE_W-1:0] nonce_out_second;
		logic [BYTE_W-1:0]  rssi_echo;
		logic               deliver_payload;
	} result_t;

	typedef struct packed {
		logic [NODE_W-1:0]  gateway_id;
		logic [TICK_W-1:0]  retry_wait;
		logic [RETRY_W-1:0] retry_limit;
	} cfg_t;

endpackage

// File: hdl/nsw_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsw_in_reg
// Input register: holds one accepted beat until the engine consumes it.
// ----------------------------------------------------------------------------
module nsw_in_reg import nsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  item_valid,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: hdl/nsw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsw_engine
// Link state and per-beat decision: nonce checks, retry timer, result select.
// ----------------------------------------------------------------------------
module nsw_engine import nsw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	logic [NONCE_W-1:0] old_rx_q, next_rx_q, next_tx_q;
	logic [RETRY_W-1:0] retries_q;
	logic [TICK_W-1:0]  elapsed_q;

	logic [NONCE_W-1:0] old_rx_d, next_rx_d, next_tx_d, fresh_adj;
	logic [RETRY_W-1:0] retries_d, retries_dec;
	logic [TICK_W-1:0]  elapsed_d, elapsed_inc;
	logic               pkt_ok;

	always_comb begin
		old_rx_d    = old_rx_q;
		next_rx_d   = next_rx_q;
		next_tx_d   = next_tx_q;
		retries_d   = retries_q;
		elapsed_d   = elapsed_q;
		res_valid   = 1'b0;
		res         = '0;
		pkt_ok      = (item.packet_length != '0) && (item.from_node == cfg.gateway_id);
		fresh_adj   = (item.fresh_nonce == next_rx_q) ?
			(item.fresh_nonce ^ NONCE_W'(1)) : item.fresh_nonce;
		elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + TICK_W'(1);
		retries_dec = retries_q - RETRY_W'(1);

		case (item.kind)
			KIND_PKT: begin
				if (pkt_ok && item.msg_type == MSG_DATA) begin
					res_valid            = 1'b1;
					res.nonce_out_first  = item.nonce_in_first;
					res.nonce_out_second = next_rx_q;
					res.rssi_echo        = item.signal_strength;
					if (item.nonce_in_first == old_rx_q) begin
						res.action = ACT_ACK;
					end else if (item.nonce_in_first != next_rx_q) begin
						res.action = ACT_NACK;
					end else begin
						old_rx_d             = next_rx_q;
						next_rx_d            = fresh_adj;
						res.action           = ACT_ACK;
						res.nonce_out_second = fresh_adj;
						res.deliver_payload  = 1'b1;
					end
				end else if (pkt_ok && (item.msg_type == MSG_ACK || item.msg_type == MSG_NACK)
						&& item.packet_length == RESP_LENGTH
						&& item.nonce_in_first == next_tx_q) begin
					next_tx_d = item.nonce_in_second;
					if (item.msg_type == MSG_ACK) begin
						retries_d  = '0;
						res_valid  = 1'b1;
						res.action = ACT_OK;
					end else if (retries_q != '0) begin
						elapsed_d           = '0;
						res_valid           = 1'b1;
						res.action          = ACT_FRAME;
						res.nonce_out_first = item.nonce_in_second;
					end
				end
			end
			KIND_SEND: begin
				retries_d           = cfg.retry_limit;
				elapsed_d           = '0;
				res_valid           = 1'b1;
				res.action          = ACT_FRAME;
				res.nonce_out_first = next_tx_q;
			end
			KIND_TICK: begin
				elapsed_d = elapsed_inc;
				if (retries_q != '0 && elapsed_inc > cfg.retry_wait) begin
					retries_d = retries_dec;
					res_valid = 1'b1;
					if (retries_dec == '0) begin
						res.action = ACT_FAIL;
					end else begin
						elapsed_d           = '0;
						res.action          = ACT_FRAME;
						res.nonce_out_first = next_tx_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_rx_q  <= '0;
			next_rx_q <= NONCE_W'(1);
			next_tx_q <= '0;
			retries_q <= '0;
			elapsed_q <= '0;
		end else if (go) begin
			old_rx_q  <= old_rx_d;
			next_rx_q <= next_rx_d;
			next_tx_q <= next_tx_d;
			retries_q <= retries_d;
			elapsed_q <= elapsed_d;
		end
	end

`ifndef SYNTHESIS
	a_nonce_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		next_rx_q != old_rx_q)
		else $error("receive nonces collapsed");

	a_send_loads: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.kind == KIND_SEND |=>
		elapsed_q == '0 && retries_q == $past(cfg.retry_limit))
		else $error("send request did not restart timer and retries");

	a_deliver_rolls: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && res.deliver_payload |=> old_rx_q == $past(next_rx_q))
		else $error("delivered packet did not roll receive nonce");

	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && (res.action == ACT_FAIL || res.action == ACT_OK) |=>
		retries_q == '0)
		else $error("finished send still pending");
`endif

endmodule

// File: hdl/nsw_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsw_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module nsw_out_reg import nsw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_s2;
	result_t res_s2;

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

// File: hdl/nonce_stop_and_wait_link.sv
`timescale 1ns / 1ps
// Sensor side of a nonce-checked stop-and-wait link. Each input beat is a
// received packet header, a send request or a one millisecond tick, selected
// by s_tuser; each yields at most one result beat (ack, nack, data frame,
// send ok or send failed). A beat passes an input register, is decided against
// the link state and is loaded into a result register; one beat is taken every
// cycle while the result register is not stalled, and only a stalled result
// register holds back input. Configuration writes take effect on the next edge.
// ----------------------------------------------------------------------------
// nonce_stop_and_wait_link
// Top level: stream ports, configuration registers, input/engine/output.
// ----------------------------------------------------------------------------
module nonce_stop_and_wait_link import nsw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// from_node, msg_type, packet_length, nonce_in_first, nonce_in_second,
	// signal_strength, fresh_nonce
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// nonce_out_first, nonce_out_second, rssi_echo
	output logic [OUT_DATA_W-1:0] m_tdata,
	// action, deliver_payload
	output logic [OUT_USER_W-1:0] m_tuser
);

	cfg_t    cfg_q;
	item_t   in_item, item;
	logic    item_valid, advance, res_valid;
	result_t res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gateway_id  <= GATEWAY_ID_RST;
			cfg_q.retry_wait  <= RETRY_WAIT_RST;
			cfg_q.retry_limit <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GATEWAY_ID:  cfg_q.gateway_id  <= cfg_data[NODE_W-1:0];
				CFG_RETRY_WAIT:  cfg_q.retry_wait  <= cfg_data[TICK_W-1:0];
				CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data[RETRY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_item.kind            = s_tuser;
	assign in_item.from_node       = s_tdata[7:0];
	assign in_item.msg_type        = s_tdata[15:8];
	assign in_item.packet_length   = s_tdata[23:16];
	assign in_item.nonce_in_first  = s_tdata[55:24];
	assign in_item.nonce_in_second = s_tdata[87:56];
	assign in_item.signal_strength = s_tdata[95:88];
	assign in_item.fresh_nonce     = s_tdata[127:96];

	assign advance = item_valid && (!m_tvalid || m_tready);

	nsw_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	nsw_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.item      (item),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	nsw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.rssi_echo, out_res.nonce_out_second, out_res.nonce_out_first};
	assign m_tuser = {out_res.deliver_payload, out_res.action};

endmodule

// File: verif/nsw_link_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsw_link_checker
// Watches the configuration port and both stream channels of the link. Every
// accepted input beat is run through a local model of the nonce and retry
// state, and any response it causes is queued. Every output beat is compared
// field by field against the oldest queued response. Reports a mismatch
// count, the number of responses still owed, and the current nonce state as
// hints for stimulus.
// ----------------------------------------------------------------------------
module nsw_link_checker import nsw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// from_node, msg_type, packet_length, nonce_in_first, nonce_in_second,
	// signal_strength, fresh_nonce
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// nonce_out_first, nonce_out_second, rssi_echo
	input  logic [OUT_DATA_W-1:0] m_tdata,
	// action, deliver_payload
	input  logic [OUT_USER_W-1:0] m_tuser,
	output int                    fail_count,
	output int                    owed_count,
	output logic [NONCE_W-1:0]    rx_next_hint,
	output logic [NONCE_W-1:0]    rx_old_hint,
	output logic [NONCE_W-1:0]    tx_nonce_hint
);

	cfg_t               link_cfg;
	logic [NONCE_W-1:0] rx_old;
	logic [NONCE_W-1:0] rx_next;
	logic [NONCE_W-1:0] tx_nonce;
	logic [RETRY_W-1:0] retries;
	logic [TICK_W-1:0]  elapsed;
	result_t            owed_resp_q[$];
	int                 errors = 0;

	assign fail_count = errors;

	task automatic report(input string what, input logic [NONCE_W-1:0] want,
			input logic [NONCE_W-1:0] got);
		errors++;
		$display("%0t nsw_link_checker: %s expected %0h got %0h", $time, what, want, got);
	endtask

	function automatic bit send_frame(output result_t r);
		elapsed = '0;
		r = '0;
		r.action = ACT_FRAME;
		r.nonce_out_first = tx_nonce;
		return 1'b1;
	endfunction

	function automatic bit advance_link(input item_t it, output result_t r);
		r = '0;
		case (it.kind)
			KIND_PKT: begin
				if (it.packet_length == '0 || it.from_node != link_cfg.gateway_id)
					return 1'b0;
				if (it.msg_type == MSG_DATA) begin
					r.nonce_out_first = it.nonce_in_first;
					r.rssi_echo = it.signal_strength;
					if (it.nonce_in_first == rx_old) begin
						r.action = ACT_ACK;
						r.nonce_out_second = rx_next;
						return 1'b1;
					end
					if (it.nonce_in_first != rx_next) begin
						r.action = ACT_NACK;
						r.nonce_out_second = rx_next;
						return 1'b1;
					end
					rx_old = rx_next;
					rx_next = (it.fresh_nonce == rx_old) ? it.fresh_nonce ^ 32'd1
						: it.fresh_nonce;
					r.action = ACT_ACK;
					r.nonce_out_second = rx_next;
					r.deliver_payload = 1'b1;
					return 1'b1;
				end
				if (it.msg_type == MSG_ACK || it.msg_type == MSG_NACK) begin
					if (it.packet_length != RESP_LENGTH || it.nonce_in_first != tx_nonce)
						return 1'b0;
					tx_nonce = it.nonce_in_second;
					if (it.msg_type == MSG_ACK) begin
						retries = '0;
						r.action = ACT_OK;
						return 1'b1;
					end
					if (retries != '0)
						return send_frame(r);
				end
				return 1'b0;
			end
			KIND_SEND: begin
				retries = link_cfg.retry_limit;
				return send_frame(r);
			end
			KIND_TICK: begin
				if (elapsed != TICK_MAX)
					elapsed++;
				if (retries != '0 && elapsed > link_cfg.retry_wait) begin
					retries--;
					if (retries == '0) begin
						r.action = ACT_FAIL;
						return 1'b1;
					end
					return send_frame(r);
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t want;
		result_t got;
		if (!arst_n) begin
			link_cfg.gateway_id = GATEWAY_ID_RST;
			link_cfg.retry_wait = RETRY_WAIT_RST;
			link_cfg.retry_limit = RETRY_LIMIT_RST;
			rx_old = '0;
			rx_next = 32'd1;
			tx_nonce = '0;
			retries = '0;
			elapsed = '0;
			owed_resp_q.delete();
			owed_count <= 0;
			rx_next_hint <= 32'd1;
			rx_old_hint <= '0;
			tx_nonce_hint <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.action = m_tuser[ACT_W-1:0];
				got.deliver_payload = m_tuser[ACT_W];
				got.nonce_out_first = m_tdata[31:0];
				got.nonce_out_second = m_tdata[63:32];
				got.rssi_echo = m_tdata[71:64];
				if (owed_resp_q.size() == 0) begin
					report("result beat with none owed, action", '0,
						NONCE_W'(got.action));
				end else begin
					want = owed_resp_q.pop_front();
					if (got.action !== want.action)
						report("action", NONCE_W'(want.action), NONCE_W'(got.action));
					if (got.nonce_out_first !== want.nonce_out_first)
						report("nonce_out_first", want.nonce_out_first, got.nonce_out_first);
					if (got.nonce_out_second !== want.nonce_out_second)
						report("nonce_out_second", want.nonce_out_second,
							got.nonce_out_second);
					if (got.rssi_echo !== want.rssi_echo)
						report("rssi_echo", NONCE_W'(want.rssi_echo),
							NONCE_W'(got.rssi_echo));
					if (got.deliver_payload !== want.deliver_payload)
						report("deliver_payload", NONCE_W'(want.deliver_payload),
							NONCE_W'(got.deliver_payload));
				end
			end
			if (s_tvalid && s_tready) begin
				it.kind = s_tuser;
				it.from_node = s_tdata[7:0];
				it.msg_type = s_tdata[15:8];
				it.packet_length = s_tdata[23:16];
				it.nonce_in_first = s_tdata[55:24];
				it.nonce_in_second = s_tdata[87:56];
				it.signal_strength = s_tdata[95:88];
				it.fresh_nonce = s_tdata[127:96];
				if (advance_link(it, want))
					owed_resp_q.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_GATEWAY_ID:  link_cfg.gateway_id = cfg_data[NODE_W-1:0];
					CFG_RETRY_WAIT:  link_cfg.retry_wait = cfg_data[TICK_W-1:0];
					CFG_RETRY_LIMIT: link_cfg.retry_limit = cfg_data[RETRY_W-1:0];
					default: ;
				endcase
			end
			owed_count <= owed_resp_q.size();
			rx_next_hint <= rx_next;
			rx_old_hint <= rx_old;
			tx_nonce_hint <= tx_nonce;
		end
	end

endmodule

// File: verif/nonce_stop_and_wait_link_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonce_stop_and_wait_link_tb
// Drives the link with directed packet, send and tick beats, then with
// random traffic steered by the checker's nonce hints under several register
// settings, and finally with a tick run while the retry timer is out of
// reach. The sender bursts and pauses, the receiver stalls at random and
// once holds off long enough to back up the input. Verdict comes from the
// checker's mismatch count and a cycle limit.
// ----------------------------------------------------------------------------
module nonce_stop_and_wait_link_tb;
	import nsw_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 100000;
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BEATS = 135;
	localparam int LONG_TICKS = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	int                 fail_count;
	int                 owed_count;
	logic [NONCE_W-1:0] rx_next_hint;
	logic [NONCE_W-1:0] rx_old_hint;
	logic [NONCE_W-1:0] tx_nonce_hint;

	logic [NODE_W-1:0] gw_cur = GATEWAY_ID_RST;
	int                hold_req = 0;
	int                hold_done = 0;
	int                burst_left = 0;
	int                cycles = 0;

	nonce_stop_and_wait_link u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	nsw_link_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.owed_count    (owed_count),
		.rx_next_hint  (rx_next_hint),
		.rx_old_hint   (rx_old_hint),
		.tx_nonce_hint (tx_nonce_hint)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("nonce_stop_and_wait_link_tb: FAIL");
			$finish;
		end
	end

	// receiver: stretches of random stall, plus a long hold-off on request
	initial begin
		int run_left;
		int stall_pct;
		run_left = 0;
		stall_pct = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_done != hold_req) begin
				hold_done = hold_req;
				m_tready <= 1'b0;
				for (int c = 1; c < HOLD_CYCLES; c++)
					@(posedge clk);
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(5, 40);
					stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 70);
				end
				run_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic item_t link_beat(input logic [KIND_W-1:0] kind,
			input logic [NODE_W-1:0] from_node, input logic [BYTE_W-1:0] msg_type,
			input logic [BYTE_W-1:0] packet_length, input logic [NONCE_W-1:0] n1,
			input logic [NONCE_W-1:0] n2, input logic [BYTE_W-1:0] rssi,
			input logic [NONCE_W-1:0] fresh);
		item_t it;
		it.kind = kind;
		it.from_node = from_node;
		it.msg_type = msg_type;
		it.packet_length = packet_length;
		it.nonce_in_first = n1;
		it.nonce_in_second = n2;
		it.signal_strength = rssi;
		it.fresh_nonce = fresh;
		return it;
	endfunction

	function automatic item_t next_link_beat(input bit want_result);
		item_t it;
		int    r;
		int    m;
		int    q;
		it = link_beat(KIND_PKT, NODE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
			$urandom, $urandom, BYTE_W'($urandom), $urandom);
		if ($urandom_range(0, 6) == 0)
			it.fresh_nonce = rx_next_hint;
		r = want_result ? 0 : $urandom_range(0, 99);
		if (r < 45) begin
			it.kind = KIND_PKT;
			if (want_result || $urandom_range(0, 11) != 0)
				it.from_node = gw_cur;
			m = want_result ? 0 : $urandom_range(0, 19);
			if (m < 10) begin
				it.msg_type = MSG_DATA;
				it.packet_length = BYTE_W'($urandom_range(1, 255));
				q = $urandom_range(0, 9);
				if (q < 5)
					it.nonce_in_first = rx_next_hint;
				else if (q < 7)
					it.nonce_in_first = rx_old_hint;
			end else if (m < 17) begin
				it.msg_type = (m < 14) ? MSG_ACK : MSG_NACK;
				if ($urandom_range(0, 7) != 0)
					it.packet_length = RESP_LENGTH;
				if ($urandom_range(0, 4) != 0)
					it.nonce_in_first = tx_nonce_hint;
			end
			if (!want_result && $urandom_range(0, 24) == 0)
				it.packet_length = '0;
		end else if (r < 58) begin
			it.kind = KIND_SEND;
		end else if (r < 97) begin
			it.kind = KIND_TICK;
		end else begin
			it.kind = KIND_UNUSED;
		end
		return it;
	endfunction

	task automatic put(input item_t it);
		s_tdata <= {it.fresh_nonce, it.signal_strength, it.nonce_in_second,
			it.nonce_in_first, it.packet_length, it.msg_type, it.from_node};
		s_tuser <= it.kind;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_cfg(input logic [NODE_W-1:0] gw, input logic [TICK_W-1:0] iv,
			input logic [RETRY_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GATEWAY_ID;
		cfg_data <= {8'h00, gw};
		@(posedge clk);
		cfg_index <= CFG_RETRY_WAIT;
		cfg_data <= iv;
		@(posedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= {8'h00, lim};
		@(posedge clk);
		cfg_we <= 1'b0;
		gw_cur = gw;
	endtask

	task automatic send_and_tick(input int ticks);
		put(link_beat(KIND_SEND, '0, '0, '0, '0, '0, '0, '0));
		repeat (ticks) put(link_beat(KIND_TICK, '0, '0, '0, '0, '0, '0, '0));
		drain();
	endtask

	task automatic run_random(input int beats, input bit pressure);
		bit want;
		for (int i = 0; i < beats; i++) begin
			want = pressure && i >= 20 && i < 50;
			if (pressure && i == 20)
				hold_req++;
			put(next_link_beat(want));
			if (pressure && i == 100) begin
				drain();
			end else if (!want) begin
				burst_left--;
				if (burst_left <= 0) begin
					idle_gap($urandom_range(1, 6));
					burst_left = $urandom_range(1, 30);
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: gateway 1, interval 200, limit 5
		put(link_beat(KIND_PKT, 8'd1, MSG_DATA, 8'd9, 32'd1, 32'd0, 8'h00, 32'd1));
		put(link_beat(KIND_PKT, 8'd1, MSG_DATA, 8'd9, 32'd1, 32'd0, 8'h5A, 32'd7));
		put(link_beat(KIND_PKT, 8'd1, MSG_DATA, 8'd1, '1, '1, 8'h80, 32'd7));
		put(link_beat(KIND_PKT, 8'd1, MSG_DATA, 8'hFF, 32'd0, 32'd0, 8'hFF, '1));
		put(link_beat(KIND_PKT, 8'd2, MSG_DATA, 8'd9, '1, '0, 8'h11, 32'd3));
		put(link_beat(KIND_PKT, 8'd1, MSG_DATA, 8'd0, '1, '0, 8'h11, 32'd3));
		put(link_beat(KIND_PKT, 8'd1, 8'h00, 8'd9, '1, '0, 8'h11, 32'd3));
		put(link_beat(KIND_PKT, 8'd1, 8'hFF, RESP_LENGTH, '0, '1, 8'h11, 32'd3));
		put(link_beat(KIND_UNUSED, '1, '1, '1, '1, '1, '1, '1));
		put(link_beat(KIND_SEND, '0, '0, '0, '0, '0, '0, '0));
		put(link_beat(KIND_PKT, 8'd1, MSG_ACK, 8'd9, 32'd0, 32'd9, 8'h01, '0));
		put(link_beat(KIND_PKT, 8'd1, MSG_ACK, RESP_LENGTH, 32'd5, 32'd9, 8'h01, '0));
		put(link_beat(KIND_PKT, 8'd1, MSG_NACK, RESP_LENGTH, 32'd0, '1, 8'h01, '0));
		put(link_beat(KIND_SEND, '0, '0, '0, '0, '0, '0, '0));
		put(link_beat(KIND_PKT, 8'd1, MSG_ACK, RESP_LENGTH, '1, 32'h1234_5678, 8'h01, '0));
		put(link_beat(KIND_PKT, 8'd1, MSG_ACK, RESP_LENGTH, 32'h1234_5678, 32'hA5A5_A5A5,
			8'h02, '0));
		put(link_beat(KIND_PKT, 8'd1, MSG_NACK, RESP_LENGTH, 32'hA5A5_A5A5, 32'd0, 8'h03,
			'0));
		put(link_beat(KIND_TICK, '0, '0, '0, '0, '0, '0, '0));
		drain();

		// single retry allowed: transmit, then fail
		set_cfg(8'h00, 16'd1, 8'd1);
		put(link_beat(KIND_PKT, 8'h00, MSG_DATA, 8'd4, '0, '0, 8'h33, 32'hDEAD_BEEF));
		send_and_tick(2);
		// zero limit: transmit once, nothing left pending
		set_cfg(8'h00, 16'd1, 8'd0);
		send_and_tick(3);
		// one retransmit on timeout before failing
		set_cfg(8'hFF, 16'd1, 8'd2);
		put(link_beat(KIND_PKT, 8'hFF, MSG_DATA, 8'd4, '1, '0, 8'h44, 32'd0));
		send_and_tick(4);

		set_cfg(NODE_W'($urandom_range(0, 255)), TICK_W'($urandom_range(1, 3)),
			RETRY_W'($urandom_range(1, 4)));
		run_random(PHASE_BEATS, 1'b1);
		set_cfg(8'hFF, 16'd2, 8'hFF);
		run_random(PHASE_BEATS, 1'b0);
		set_cfg(8'h00, 16'd1, 8'd1);
		run_random(PHASE_BEATS, 1'b0);
		set_cfg(NODE_W'($urandom_range(0, 255)), TICK_W'($urandom_range(1, 65535)),
			RETRY_W'($urandom_range(1, 255)));
		run_random(PHASE_BEATS, 1'b0);

		// tick run with a send pending and the retry timer out of reach
		set_cfg(8'h01, '1, 8'hFF);
		put(link_beat(KIND_SEND, '0, '0, '0, '0, '0, '0, '0));
		for (int i = 0; i < LONG_TICKS; i++)
			put(link_beat(KIND_TICK, '0, '0, '0, '0, '0, '0, '0));
		drain();
		set_cfg(8'h01, 16'hFFFE, 8'hFF);
		put(link_beat(KIND_TICK, '0, '0, '0, '0, '0, '0, '0));
		put(link_beat(KIND_PKT, 8'h01, MSG_ACK, RESP_LENGTH, tx_nonce_hint, 32'd77, 8'h55,
			'0));
		drain();

		if (fail_count == 0)
			$display("nonce_stop_and_wait_link_tb: PASS");
		else
			$display("nonce_stop_and_wait_link_tb: FAIL");
		$finish;
	end

endmodule
